### hw/rtl/ppa_pkg.sv
`timescale 1ns / 1ps
package ppa_pkg;

  localparam int unsigned StatusW = 3;
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StDup      = 3'd1;
  localparam logic [StatusW-1:0] StNoSpace  = 3'd2;
  localparam logic [StatusW-1:0] StFull     = 3'd3;
  localparam logic [StatusW-1:0] StNotFound = 3'd4;

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolExact = 2'd1;
  localparam logic [1:0] PolBest  = 2'd2;
  localparam logic [1:0] PolWorst = 2'd3;

  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgLimit  = 1'b1;
  localparam logic [7:0] LimitReset = 8'd80;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, clear scan state
    logic scan_step;  // examine one table slot / gap
    logic fallback;   // exact-fit scan missed: rerun as first fit
    logic shift_step; // move one entry for insert or remove
    logic commit;     // write new entry / clear top valid
  } ppa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic exact_miss;
    logic shift_done;
    logic ok;         // scan produced a placement or a found entry
  } ppa_sts_t;

endpackage

### hw/rtl/ppa_datapath.sv
`timescale 1ns / 1ps
module ppa_datapath #(
  parameter int unsigned HEAP_UNITS = 128,
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ppa_pkg::ppa_cmd_t       cmd_i,
  output ppa_pkg::ppa_sts_t       sts_o,
  input  logic [1:0]              policy_i,
  input  logic [7:0]              limit_i,
  input  logic                    kind_i,
  input  logic [7:0]              id_i,
  input  logic [7:0]              size_i,
  output logic [2:0]              status_o,
  output logic [6:0]              start_o
);
  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AddrW = $clog2(HEAP_UNITS + 1) + 1;

  logic [MAX_BLOCKS-1:0] valid_q;
  logic [7:0]       id_mem    [MAX_BLOCKS];
  logic [AddrW-1:0] start_mem [MAX_BLOCKS];
  logic [AddrW-1:0] size_mem  [MAX_BLOCKS];

  logic             kind_q;
  logic [7:0]       id_q, size_q;
  logic [1:0]       mode_q;
  logic [CntW-1:0]  g_q, n_q, found_q, pick_q, sh_q;
  logic             found_v_q, pick_v_q, exhit_q;
  logic [AddrW-1:0] lo_q, best_q, pstart_q, lim_q, fstart_q;
  logic [AddrW-1:0] hi, glen, ent_end;
  logic             at_end, fit;

  // count of packed valid entries
  logic [CntW-1:0] n_cnt;
  always_comb begin
    n_cnt = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) if (valid_q[i]) n_cnt = n_cnt + CntW'(1);
  end

  assign at_end = (g_q == n_q);
  always_comb begin
    hi = at_end ? lim_q : start_mem[g_q[IdxW-1:0]];
    if (hi > lim_q) hi = lim_q;
    glen = (hi > lo_q) ? hi - lo_q : '0;
    ent_end = start_mem[g_q[IdxW-1:0]] + size_mem[g_q[IdxW-1:0]];
    fit = (glen >= AddrW'(size_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit && sts_o.ok) begin
      if (kind_q == ppa_pkg::KindAlloc) valid_q[n_q[IdxW-1:0]] <= 1'b1;
      else valid_q[n_q[IdxW-1:0] - IdxW'(1)] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i; id_q <= id_i; size_q <= size_i;
      mode_q <= policy_i;
      lim_q <= (AddrW'(limit_i) > AddrW'(HEAP_UNITS)) ? AddrW'(HEAP_UNITS)
                                                       : AddrW'(limit_i);
      n_q <= n_cnt; g_q <= '0; lo_q <= '0;
      found_v_q <= 1'b0; pick_v_q <= 1'b0; exhit_q <= 1'b0;
    end else if (cmd_i.fallback) begin
      mode_q <= ppa_pkg::PolFirst; g_q <= '0; lo_q <= '0; pick_v_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (!at_end) begin
        // keep the start of a hit: the shift overwrites it before the result
        if (!found_v_q && id_mem[g_q[IdxW-1:0]] == id_q) begin
          found_v_q <= 1'b1; found_q <= g_q;
          fstart_q <= start_mem[g_q[IdxW-1:0]];
        end
        lo_q <= ent_end;
      end
      if (size_q != 8'd0) begin
        if (mode_q == ppa_pkg::PolExact) begin
          if (!exhit_q && glen == AddrW'(size_q)) begin
            exhit_q <= 1'b1; pick_v_q <= 1'b1; pick_q <= g_q; pstart_q <= lo_q;
          end
        end else if (fit && (!pick_v_q ||
                   (mode_q == ppa_pkg::PolBest && glen < best_q) ||
                   (mode_q == ppa_pkg::PolWorst && glen > best_q))) begin
          pick_v_q <= 1'b1; pick_q <= g_q; best_q <= glen; pstart_q <= lo_q;
          if (mode_q == ppa_pkg::PolFirst) exhit_q <= 1'b1;
        end
        if (mode_q == ppa_pkg::PolFirst && exhit_q) pick_v_q <= 1'b1;
      end
      if (!at_end) g_q <= g_q + CntW'(1);
      sh_q <= (kind_q == ppa_pkg::KindAlloc) ? n_q : found_q;
    end else if (cmd_i.shift_step) begin
      if (kind_q == ppa_pkg::KindAlloc) begin
        id_mem[sh_q[IdxW-1:0]]    <= id_mem[sh_q[IdxW-1:0] - IdxW'(1)];
        start_mem[sh_q[IdxW-1:0]] <= start_mem[sh_q[IdxW-1:0] - IdxW'(1)];
        size_mem[sh_q[IdxW-1:0]]  <= size_mem[sh_q[IdxW-1:0] - IdxW'(1)];
        sh_q <= sh_q - CntW'(1);
      end else begin
        id_mem[sh_q[IdxW-1:0]]    <= id_mem[sh_q[IdxW-1:0] + IdxW'(1)];
        start_mem[sh_q[IdxW-1:0]] <= start_mem[sh_q[IdxW-1:0] + IdxW'(1)];
        size_mem[sh_q[IdxW-1:0]]  <= size_mem[sh_q[IdxW-1:0] + IdxW'(1)];
        sh_q <= sh_q + CntW'(1);
      end
    end else if (cmd_i.commit && sts_o.ok && kind_q == ppa_pkg::KindAlloc) begin
      id_mem[pick_q[IdxW-1:0]]    <= id_q;
      start_mem[pick_q[IdxW-1:0]] <= pstart_q;
      size_mem[pick_q[IdxW-1:0]]  <= AddrW'(size_q);
    end
  end

  logic full;
  assign full = (n_q == CntW'(MAX_BLOCKS));
  // scan finishes after the tail gap (slot n) has been examined
  assign sts_o.scan_done  = at_end;
  assign sts_o.exact_miss = (mode_q == ppa_pkg::PolExact) && !exhit_q
                            && kind_q == ppa_pkg::KindAlloc && !found_v_q
                            && !full && size_q != 8'd0;
  assign sts_o.shift_done = (kind_q == ppa_pkg::KindAlloc) ? (sh_q == pick_q)
                          : (sh_q + CntW'(1) >= n_q);
  assign sts_o.ok = (kind_q == ppa_pkg::KindAlloc)
                    ? (!found_v_q && !full && pick_v_q) : found_v_q;

  always_comb begin
    status_o = ppa_pkg::StOk;
    start_o  = '0;
    if (kind_q == ppa_pkg::KindAlloc) begin
      if (found_v_q) status_o = ppa_pkg::StDup;
      else if (full) status_o = ppa_pkg::StFull;
      else if (!pick_v_q) status_o = ppa_pkg::StNoSpace;
      else start_o = pstart_q[6:0];
    end else begin
      if (!found_v_q) status_o = ppa_pkg::StNotFound;
      else start_o = fstart_q[6:0];
    end
  end

  valid_packed_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & (valid_q + MAX_BLOCKS'(1))) == '0)
    else $error("valid table not packed");
  scan_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> g_q <= n_q) else $error("scan past end");
  commit_shift_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !cmd_i.shift_step && !cmd_i.scan_step)
    else $error("commit overlaps");
endmodule

### hw/rtl/ppa_ctrl.sv
`timescale 1ns / 1ps
module ppa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ppa_pkg::ppa_cmd_t cmd_o,
  input  ppa_pkg::ppa_sts_t sts_i
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FALL  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_FALL;
      end
      S_FALL: begin
        if (sts_i.exact_miss) begin
          cmd_o.fallback = 1'b1; state_d = S_SCAN;
        end else if (sts_i.ok) state_d = S_SHIFT;
        else state_d = S_OUT;
      end
      S_SHIFT: begin
        if (sts_i.shift_done) state_d = S_DONE;
        else cmd_o.shift_step = 1'b1;
      end
      S_DONE: begin
        cmd_o.commit = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### hw/rtl/placement_policy_allocator_top.sv
`timescale 1ns / 1ps
// channel  | direction | contents
// s_axis   | in        | tuser: kind; tdata: block_id[7:0] request_size[15:8]
// m_axis   | out       | tdata: status[2:0] block_start[9:3]
// cfg      | in        | cfg_we_i, cfg_idx_i (0 policy, 1 limit), cfg_wdata_i
// For each item the table scan visits one slot per cycle, then one entry
// moves per cycle.
// An exact-fit miss rescans the table as first fit.
// Reset clears the valid bits, the state and the config registers;
// table contents need no clearing.
// Input is taken only when idle; the result holds until m_axis_tready.
module placement_policy_allocator_top #(
  parameter int unsigned HEAP_UNITS = 128,
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,  // kind
  input  logic [15:0] s_axis_tdata,  // block_id, request_size
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status, block_start
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  logic [1:0] policy_q;
  logic [7:0] limit_q;
  ppa_pkg::ppa_cmd_t cmd;
  ppa_pkg::ppa_sts_t sts;
  logic [2:0] status;
  logic [6:0] start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= ppa_pkg::PolFirst;
      limit_q  <= ppa_pkg::LimitReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ppa_pkg::CfgPolicy) policy_q <= cfg_wdata_i[1:0];
      else limit_q <= cfg_wdata_i;
    end
  end

  ppa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  ppa_datapath #(.HEAP_UNITS(HEAP_UNITS), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .policy_i(policy_q), .limit_i(limit_q),
    .kind_i(s_axis_tuser), .id_i(s_axis_tdata[7:0]),
    .size_i(s_axis_tdata[15:8]),
    .status_o(status), .start_o(start)
  );

  assign m_axis_tdata = {6'd0, start, status};
endmodule

### verif/placement_policy_allocator_top_tb.sv
`timescale 1ns / 1ps
module placement_policy_allocator_top_tb;

  localparam int unsigned HeapUnits = 128;
  localparam int unsigned MaxBlocks = 16;
  localparam int unsigned NumRandom = 1530;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] start;
  } alloc_result_t;

  // Mirror of the block table plus the expected results still in flight.
  class alloc_scoreboard;
    logic [1:0] policy;
    logic [7:0] limit;
    int unsigned n_used;
    logic [7:0] ids[MaxBlocks];
    int unsigned starts[MaxBlocks];
    int unsigned sizes[MaxBlocks];
    alloc_result_t pending_q[$];
    int unsigned fail_count;

    function void clear();
      policy = ppa_pkg::PolFirst;
      limit = ppa_pkg::LimitReset;
      n_used = 0;
      pending_q.delete();
      fail_count = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == ppa_pkg::CfgPolicy) policy = val[1:0];
      else limit = val;
    endfunction

    function int unsigned gap_low(int unsigned g);
      return g == 0 ? 0 : starts[g-1] + sizes[g-1];
    endfunction

    function int unsigned gap_len(int unsigned g);
      int unsigned lim, lo, hi;
      lim = limit > HeapUnits ? HeapUnits : limit;
      lo = gap_low(g);
      hi = (g == n_used) ? lim : starts[g];
      if (hi > lim) hi = lim;
      return hi > lo ? hi - lo : 0;
    endfunction

    function int unsigned choose_gap(int unsigned sz);
      int unsigned pick, best, len;
      logic [1:0] mode;
      pick = n_used + 1;
      best = 0;
      mode = policy;
      if (mode == ppa_pkg::PolExact) begin
        for (int unsigned g = 0; g <= n_used; g++)
          if (gap_len(g) == sz) return g;
        mode = ppa_pkg::PolFirst;
      end
      for (int unsigned g = 0; g <= n_used; g++) begin
        len = gap_len(g);
        if (len < sz) continue;
        if (mode == ppa_pkg::PolFirst) return g;
        if (pick > n_used || (mode == ppa_pkg::PolBest && len < best) ||
            (mode == ppa_pkg::PolWorst && len > best)) begin
          pick = g;
          best = len;
        end
      end
      return pick;
    endfunction

    function void note_request(logic kind, logic [7:0] id, logic [7:0] sz);
      int unsigned found, g, st;
      logic [2:0] status;
      found = n_used;
      st = 0;
      status = ppa_pkg::StOk;
      for (int unsigned i = 0; i < n_used; i++)
        if (ids[i] == id) begin
          found = i;
          break;
        end
      if (kind == ppa_pkg::KindAlloc) begin
        if (found < n_used) status = ppa_pkg::StDup;
        else if (n_used >= MaxBlocks) status = ppa_pkg::StFull;
        else if (sz == 0) status = ppa_pkg::StNoSpace;
        else begin
          g = choose_gap(sz);
          if (g > n_used) status = ppa_pkg::StNoSpace;
          else begin
            st = gap_low(g);
            for (int unsigned i = n_used; i > g; i--) begin
              ids[i] = ids[i-1];
              starts[i] = starts[i-1];
              sizes[i] = sizes[i-1];
            end
            ids[g] = id;
            starts[g] = st;
            sizes[g] = sz;
            n_used++;
          end
        end
      end else if (found >= n_used) begin
        status = ppa_pkg::StNotFound;
      end else begin
        st = starts[found];
        for (int unsigned i = found; i + 1 < n_used; i++) begin
          ids[i] = ids[i+1];
          starts[i] = starts[i+1];
          sizes[i] = sizes[i+1];
        end
        n_used--;
      end
      if (status != ppa_pkg::StOk) st = 0;
      pending_q.push_back('{status: status, start: st[6:0]});
    endfunction

    function void check_result(logic [15:0] data);
      alloc_result_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", data);
        fail_count++;
        return;
      end
      want = pending_q.pop_front();
      if (data[2:0] !== want.status) begin
        $error("status: expected %0d actual %0d", want.status, data[2:0]);
        fail_count++;
      end
      if (data[9:3] !== want.start) begin
        $error("block_start: expected %0d actual %0d", want.start, data[9:3]);
        fail_count++;
      end
      if (data[15:10] !== '0) begin
        $error("pad: expected 0 actual %h", data[15:10]);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic s_axis_tuser;
  logic [15:0] s_axis_tdata;
  logic [15:0] m_axis_tdata;
  logic cfg_we_i, cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  alloc_scoreboard sb;
  longint cycle_count;
  int unsigned hold_cycles;
  bit in_burst;

  placement_policy_allocator_top #(.HEAP_UNITS(HeapUnits), .MAX_BLOCKS(MaxBlocks)) u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("placement_policy_allocator_top test failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls per beat; a long hold-off when requested.
  initial begin
    int unsigned wait_n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      wait_n = in_burst ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata);
    end
  end

  // Valid stays up past the accepting edge only when the next beat follows
  // at once; drop it with stop_input() before anything else.
  task automatic send_req(logic kind, logic [7:0] id, logic [7:0] sz);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {sz, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(kind, id, sz);
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    stop_input();
    // let the block drain before touching its registers
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * MaxBlocks + 10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Mostly ids from a small pool so frees hit and the table fills up.
  task automatic random_req();
    logic kind;
    logic [7:0] id, sz;
    kind = ($urandom_range(0, 99) < 45) ? ppa_pkg::KindFree : ppa_pkg::KindAlloc;
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 23));
    case ($urandom_range(0, 9))
      0: sz = 8'($urandom_range(0, 255));
      1: sz = 8'($urandom_range(20, 128));
      default: sz = 8'($urandom_range(1, 12));
    endcase
    send_req(kind, id, sz);
  endtask

  initial begin
    logic [7:0] limits[6];
    int unsigned per_phase;
    sb = new();
    sb.clear();
    s_axis_tvalid = 1'b0;
    s_axis_tuser = ppa_pkg::KindAlloc;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ppa_pkg::CfgPolicy;
    cfg_wdata_i = '0;
    hold_cycles = 0;
    in_burst = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edges of fields, errors, each policy.
    send_req(ppa_pkg::KindAlloc, 8'd0, 8'd0);
    send_req(ppa_pkg::KindAlloc, 8'd255, 8'd81);
    send_req(ppa_pkg::KindAlloc, 8'd255, 8'd10);
    send_req(ppa_pkg::KindAlloc, 8'd255, 8'd5);
    send_req(ppa_pkg::KindAlloc, 8'd1, 8'd20);
    send_req(ppa_pkg::KindAlloc, 8'd2, 8'd5);
    send_req(ppa_pkg::KindAlloc, 8'd3, 8'd30);
    send_req(ppa_pkg::KindFree, 8'd1, 8'd255);
    send_req(ppa_pkg::KindFree, 8'd1, 8'd0);
    send_req(ppa_pkg::KindFree, 8'd255, 8'd0);
    write_cfg(ppa_pkg::CfgPolicy, 8'(ppa_pkg::PolExact));
    send_req(ppa_pkg::KindAlloc, 8'd4, 8'd10);
    send_req(ppa_pkg::KindAlloc, 8'd5, 8'd6);
    write_cfg(ppa_pkg::CfgPolicy, 8'(ppa_pkg::PolBest));
    send_req(ppa_pkg::KindAlloc, 8'd6, 8'd3);
    write_cfg(ppa_pkg::CfgPolicy, 8'(ppa_pkg::PolWorst));
    send_req(ppa_pkg::KindAlloc, 8'd7, 8'd2);
    write_cfg(ppa_pkg::CfgLimit, 8'd255);
    send_req(ppa_pkg::KindAlloc, 8'd8, 8'd128);
    send_req(ppa_pkg::KindAlloc, 8'd9, 8'd40);
    write_cfg(ppa_pkg::CfgLimit, 8'd0);
    send_req(ppa_pkg::KindAlloc, 8'd10, 8'd1);
    write_cfg(ppa_pkg::CfgLimit, 8'd1);
    send_req(ppa_pkg::KindAlloc, 8'd11, 8'd1);
    for (int i = 12; i < 30; i++) send_req(ppa_pkg::KindAlloc, 8'(i), 8'd1);

    // Long receiver stall while the sender keeps offering.
    hold_cycles = 400;
    in_burst = 1'b1;
    for (int i = 0; i < 6; i++) send_req(ppa_pkg::KindFree, 8'(i + 2), 8'd0);
    in_burst = 1'b0;

    limits = '{8'd128, 8'd200, 8'd40, 8'd1, 8'd100, 8'd64};
    per_phase = NumRandom / 12;
    for (int p = 0; p < 12; p++) begin
      write_cfg(ppa_pkg::CfgPolicy, 8'(p % 4));
      write_cfg(ppa_pkg::CfgLimit, limits[p % 6]);
      in_burst = (p % 5 == 2);
      for (int unsigned k = 0; k < per_phase; k++) random_req();
      in_burst = 1'b0;
    end

    stop_input();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * MaxBlocks + 20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending_q.size() == 0)
      $display("placement_policy_allocator_top test passed");
    else
      $display("placement_policy_allocator_top test failed");
    $finish;
  end
endmodule

### placement_policy_allocator_top.f
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_datapath.sv
hw/rtl/ppa_ctrl.sv
hw/rtl/placement_policy_allocator_top.sv
verif/placement_policy_allocator_top_tb.sv
